/* rtl/osfs_pkg.sv */
// ----------------------------------------------------------------------------
// osfs_pkg
// shared types, constants and fixed-point helpers of the oscillator scan
// ----------------------------------------------------------------------------
package osfs_pkg;

   localparam int VALUE_W          = 32;
   localparam int CHANNEL_W        = 4;
   localparam int PROD_W           = 48;
   localparam int SUM_W            = 50;
   localparam int MUL_LANES        = 12;
   localparam int CHANNELS_DEFAULT = 16;

   typedef logic signed [VALUE_W-1:0] fixed_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   localparam sum_type   Q_ONE     = 50'sd65536;
   localparam sum_type   SUM_MAX   = 50'sd2147483647;
   localparam sum_type   SUM_MIN   = -50'sd2147483648;
   localparam fixed_type VALUE_MAX = 32'sh7fffffff;
   localparam fixed_type VALUE_MIN = 32'sh80000000;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SMP_MUL,
      ST_SMP_SUM,
      ST_LD_MUL1,
      ST_LD_MID,
      ST_LD_MUL2,
      ST_LD_WRITE
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [CHANNEL_W-1:0]   channel;
      logic                   start_req;
      fixed_type              alpha;
      fixed_type              gamma;
      fixed_type              sigma;
      fixed_type              in_real;
      fixed_type              in_imag;
   } req_item_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]   out_channel;
      fixed_type              z_real;
      fixed_type              z_imag;
      fixed_type              x_real;
      fixed_type              x_imag;
      logic                   saturated;
   } rsp_item_type;

   typedef struct packed {
      fixed_type m11;
      fixed_type m12;
      fixed_type m21;
      fixed_type m22;
      fixed_type step;
      fixed_type step_sq;
   } coef_word_type;

   typedef struct packed {
      fixed_type z_real;
      fixed_type z_imag;
      fixed_type x_real;
      fixed_type x_imag;
   } state_word_type;

   typedef struct packed {
      logic      clipped;
      fixed_type value;
   } clip_type;

   function automatic sum_type sext_prod(input prod_type p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   function automatic sum_type sext_value(input fixed_type v);
      return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
   endfunction

   function automatic clip_type clip32(input sum_type v);
      clip_type r;
      if (v > SUM_MAX) begin
         r.clipped = 1'b1;
         r.value   = VALUE_MAX;
      end else if (v < SUM_MIN) begin
         r.clipped = 1'b1;
         r.value   = VALUE_MIN;
      end else begin
         r.clipped = 1'b0;
         r.value   = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   function automatic clip_type sum3_clip(input prod_type a, input prod_type b,
                                          input prod_type c);
      return clip32(sext_prod(a) + sext_prod(b) + sext_prod(c));
   endfunction

endpackage

/* rtl/osfs_req_if.sv */
// ----------------------------------------------------------------------------
// osfs_req_if
// request channel: valid/ready handshake carrying one load or sample item
// ----------------------------------------------------------------------------
interface osfs_req_if import osfs_pkg::*;;
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

/* rtl/osfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// osfs_rsp_if
// response channel: valid/ready handshake carrying one new channel state
// ----------------------------------------------------------------------------
interface osfs_rsp_if import osfs_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

/* rtl/osfs_ram.sv */
// ----------------------------------------------------------------------------
// osfs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module osfs_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/oscillator_ssm_forward_scan_top.sv */
// ----------------------------------------------------------------------------
// oscillator_ssm_forward_scan_top
// per-channel damped oscillator state-space scan, signed q16.16
// ----------------------------------------------------------------------------
// req_chan takes one item per handshake: op load stores a channel's step,
// step squared and 2x2 matrix; op sample applies a complex input to the
// channel's two complex states and returns the new state on rsp_chan.
// items whose channel is not below CHANNELS are taken and dropped.
// coefficients and states live in two rams with registered read data.
// a sample goes through the ram read, twelve 32x32 multiplies, and a sum
// and clip; its item is registered on rsp_chan together with the state
// write, and the next item is accepted after that. a load has a second
// round of multiplies, since step squared has to be formed before it.
// a dropped item is taken while idle and the block stays idle. items are
// worked on one at a time, so a sample always sees the state written by
// the one before it. reset starts a clearing pass over every channel
// address that zeroes both rams; req_chan.ready stays low until it ends.
// rsp_chan has one output register: a result waits there while the
// receiver stalls, and a following sample holds in its sum stage until
// the register frees up.
// ----------------------------------------------------------------------------
module oscillator_ssm_forward_scan_top import osfs_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   osfs_req_if.sink   req_chan,
   osfs_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W  = ($clog2(CHANNELS + 1) > CHANNEL_W) ?
                           $clog2(CHANNELS + 1) : CHANNEL_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

   state_type      state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   req_item_type   item_ff, item_in;
   prod_type       prod_ff [MUL_LANES];
   prod_type       prod_in [MUL_LANES];
   logic           prod_load;
   fixed_type      mul_a [MUL_LANES];
   fixed_type      mul_b [MUL_LANES];
   logic signed [2*VALUE_W-1:0] mul_full [MUL_LANES];
   fixed_type      q_ff, q_in;
   fixed_type      m11_ff, m11_in;
   fixed_type      m12_ff, m12_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   logic           accept;
   logic           in_range;
   logic           slot_free;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] item_addr;

   logic           coef_wr_en;
   logic [ADDR_W-1:0] coef_wr_addr;
   coef_word_type  coef_wr_data;
   coef_word_type  coef_rd;
   logic           st_wr_en;
   logic [ADDR_W-1:0] st_wr_addr;
   state_word_type st_wr_data;
   state_word_type st_rd;
   state_word_type prior;

   clip_type       c_q, c_m11, c_m12, c_m21, c_m22;
   clip_type       c_n0r, c_n0i, c_n1r, c_n1i;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign in_range  = CNT_W'(req_chan.item.channel) < CNT_W'(CHANNELS);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_addr  = ADDR_W'(req_chan.item.channel);
   assign item_addr = ADDR_W'(item_ff.channel);

   // coefficient and state memories
   osfs_ram #(.WIDTH($bits(coef_word_type)), .DEPTH(CHANNELS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_addr (req_addr),
      .rd_data (coef_rd)
   );

   osfs_ram #(.WIDTH($bits(state_word_type)), .DEPTH(CHANNELS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (req_addr),
      .rd_data (st_rd)
   );

   assign prior = item_ff.start_req ? '0 : st_rd;

   // shared multiplier bank, operands chosen by state
   always_comb begin
      for (int i = 0; i < MUL_LANES; i++) begin
         mul_a[i] = '0;
         mul_b[i] = '0;
      end
      unique case (state_ff)
         ST_SMP_MUL: begin
            mul_a[0]  = prior.z_real;   mul_b[0]  = coef_rd.m11;
            mul_a[1]  = prior.x_real;   mul_b[1]  = coef_rd.m12;
            mul_a[2]  = item_ff.in_real; mul_b[2] = coef_rd.step;
            mul_a[3]  = prior.z_imag;   mul_b[3]  = coef_rd.m11;
            mul_a[4]  = prior.x_imag;   mul_b[4]  = coef_rd.m12;
            mul_a[5]  = item_ff.in_imag; mul_b[5] = coef_rd.step;
            mul_a[6]  = prior.z_real;   mul_b[6]  = coef_rd.m21;
            mul_a[7]  = prior.x_real;   mul_b[7]  = coef_rd.m22;
            mul_a[8]  = item_ff.in_real; mul_b[8] = coef_rd.step_sq;
            mul_a[9]  = prior.z_imag;   mul_b[9]  = coef_rd.m21;
            mul_a[10] = prior.x_imag;   mul_b[10] = coef_rd.m22;
            mul_a[11] = item_ff.in_imag; mul_b[11] = coef_rd.step_sq;
         end
         ST_LD_MUL1: begin
            mul_a[0] = item_ff.sigma;   mul_b[0] = item_ff.sigma;
            mul_a[1] = item_ff.sigma;   mul_b[1] = item_ff.gamma;
            mul_a[2] = item_ff.sigma;   mul_b[2] = item_ff.alpha;
         end
         ST_LD_MUL2: begin
            mul_a[0] = q_ff;            mul_b[0] = item_ff.gamma;
            mul_a[1] = q_ff;            mul_b[1] = item_ff.alpha;
         end
         ST_CLEAR, ST_IDLE, ST_SMP_SUM, ST_LD_MID, ST_LD_WRITE: begin
         end
      endcase
      for (int i = 0; i < MUL_LANES; i++) begin
         mul_full[i] = mul_a[i] * mul_b[i];
         prod_in[i]  = prod_load ? mul_full[i][2*VALUE_W-1:16] : prod_ff[i];
      end
   end

   // clipping of coefficient and state sums
   always_comb begin
      c_q   = clip32(sext_prod(prod_ff[0]));
      c_m11 = clip32(Q_ONE - sext_prod(prod_ff[1]));
      c_m12 = clip32(-sext_prod(prod_ff[2]));
      c_m21 = clip32(sext_value(item_ff.sigma) - sext_prod(prod_ff[0]));
      c_m22 = clip32(Q_ONE - sext_prod(prod_ff[1]));
      c_n0r = sum3_clip(prod_ff[0], prod_ff[1], prod_ff[2]);
      c_n0i = sum3_clip(prod_ff[3], prod_ff[4], prod_ff[5]);
      c_n1r = sum3_clip(prod_ff[6], prod_ff[7], prod_ff[8]);
      c_n1i = sum3_clip(prod_ff[9], prod_ff[10], prod_ff[11]);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      q_in         = q_ff;
      m11_in       = m11_ff;
      m12_in       = m12_ff;
      prod_load    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in  = rsp_item_ff;

      coef_wr_en   = 1'b0;
      coef_wr_addr = item_addr;
      coef_wr_data = '{m11: m11_ff, m12: m12_ff, m21: c_m21.value, m22: c_m22.value,
                       step: item_ff.sigma, step_sq: q_ff};
      st_wr_en     = 1'b0;
      st_wr_addr   = item_addr;
      st_wr_data   = '{z_real: c_n0r.value, z_imag: c_n0i.value,
                       x_real: c_n1r.value, x_imag: c_n1i.value};

      unique case (state_ff)
         ST_CLEAR: begin
            coef_wr_en   = 1'b1;
            coef_wr_addr = clr_addr_ff;
            coef_wr_data = '0;
            st_wr_en     = 1'b1;
            st_wr_addr   = clr_addr_ff;
            st_wr_data   = '0;
            clr_addr_in  = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_chan.item;
               if (in_range) begin
                  state_in = (req_chan.item.op == OP_LOAD) ? ST_LD_MUL1 : ST_SMP_MUL;
               end
            end
         end
         ST_SMP_MUL: begin
            prod_load = 1'b1;
            state_in  = ST_SMP_SUM;
         end
         ST_SMP_SUM: begin
            if (slot_free) begin
               st_wr_en     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{out_channel: item_ff.channel,
                                z_real: c_n0r.value, z_imag: c_n0i.value,
                                x_real: c_n1r.value, x_imag: c_n1i.value,
                                saturated: c_n0r.clipped | c_n0i.clipped |
                                           c_n1r.clipped | c_n1i.clipped};
               state_in     = ST_IDLE;
            end
         end
         ST_LD_MUL1: begin
            prod_load = 1'b1;
            state_in  = ST_LD_MID;
         end
         ST_LD_MID: begin
            q_in     = c_q.value;
            m11_in   = c_m11.value;
            m12_in   = c_m12.value;
            state_in = ST_LD_MUL2;
         end
         ST_LD_MUL2: begin
            prod_load = 1'b1;
            state_in  = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            coef_wr_en = 1'b1;
            state_in   = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      q_ff        <= q_in;
      m11_ff      <= m11_in;
      m12_ff      <= m12_in;
      rsp_item_ff <= rsp_item_in;
      for (int i = 0; i < MUL_LANES; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item  = rsp_item_ff;

endmodule
